// File: rtl/core/sqws_pkg.sv
// ----------------------------------------------------------------------------
// sqws_pkg
// Shared constants and helpers for the shell-style word splitter.
// ----------------------------------------------------------------------------
package sqws_pkg;

    localparam int BYTE_W  = 8;
    localparam int PHASE_W = 2;

    // Scan phase codes.
    localparam logic [PHASE_W-1:0] PH_SEP   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_WORD  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_QUOTE = 2'd2;

    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;

    // Bit positions of the result flags in tuser.
    localparam int USR_BYTE_VALID  = 0;
    localparam int USR_WORD_END    = 1;
    localparam int USR_QUOTE_ERROR = 2;
    localparam int USR_W           = 3;

    // Space, tab, newline, vertical tab, form feed and carriage return.
    function automatic logic is_blank(input logic [BYTE_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

// File: rtl/core/shell_quote_word_splitter.sv
// ----------------------------------------------------------------------------
// shell_quote_word_splitter
// Splits a command string, one byte per request, into shell-style words.
// ----------------------------------------------------------------------------
// Each accepted input byte produces exactly one result: an optional word byte,
// a word-end flag, and on the last byte of a command (tlast) a final word end
// or a quote error. Quotes group text and are dropped; a backslash makes the
// next byte literal, also inside quotes, except as the last byte where it is
// kept. Throughput is one byte per cycle while the result side does not stall.
// Each accepted request waits in the input register and moves on into the
// result register once that register is free (one input register, one result
// register). The scanner state is updated as each byte moves into the result
// register, so back-to-back bytes see the state left by their predecessor.
module shell_quote_word_splitter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [sqws_pkg::BYTE_W-1:0]  i_s_tdata,   // [7:0] in_byte
    input  logic                         i_s_tlast,   // is_final
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [sqws_pkg::BYTE_W-1:0]  o_m_tdata,   // [7:0] word_byte
    output logic [sqws_pkg::USR_W-1:0]   o_m_tuser,   // [0] byte_valid, [1] word_end,
                                                      // [2] quote_error
    output logic                         o_m_tlast    // command_done
);
    import sqws_pkg::*;

    // Input register.
    logic                r_in_valid;
    logic [BYTE_W-1:0]   r_in_byte;
    logic                r_in_last;

    // Scanner state.
    logic [PHASE_W-1:0]  r_phase;
    logic                r_quote_dbl;
    logic                r_esc_pending;

    // Result register.
    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_out_byte;
    logic [USR_W-1:0]    r_out_user;
    logic                r_out_last;

    logic                w_out_free;
    logic                w_adv;

    logic [PHASE_W-1:0]  n_phase;
    logic                n_quote_dbl;
    logic                n_esc_pending;
    logic                n_valid;
    logic                n_wend;
    logic                n_qerr;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_adv      = r_in_valid && w_out_free;
    assign o_s_tready = !r_in_valid || w_out_free;

    always_comb begin
        logic [PHASE_W-1:0] ph;
        logic [BYTE_W-1:0]  q;
        ph            = (r_phase == PH_WORD || r_phase == PH_QUOTE) ? r_phase : PH_SEP;
        q             = r_quote_dbl ? CH_DQUOTE : CH_SQUOTE;
        n_quote_dbl   = r_quote_dbl;
        n_esc_pending = r_esc_pending;
        n_valid       = 1'b0;
        n_wend        = 1'b0;
        n_qerr        = 1'b0;

        priority if (r_esc_pending) begin
            n_esc_pending = 1'b0;
            n_valid       = 1'b1;
            if (ph == PH_SEP) begin
                ph = PH_WORD;
            end
        end else if (r_in_byte == CH_BSLASH && !r_in_last) begin
            n_esc_pending = 1'b1;
            if (ph == PH_SEP) begin
                ph = PH_WORD;
            end
        end else if (ph == PH_QUOTE) begin
            if (r_in_byte == q) begin
                ph = PH_WORD;
            end else begin
                n_valid = 1'b1;
            end
        end else if (is_blank(r_in_byte)) begin
            if (ph == PH_WORD) begin
                n_wend = 1'b1;
                ph     = PH_SEP;
            end
        end else if (r_in_byte == CH_SQUOTE || r_in_byte == CH_DQUOTE) begin
            ph          = PH_QUOTE;
            n_quote_dbl = (r_in_byte == CH_DQUOTE);
        end else begin
            ph      = PH_WORD;
            n_valid = 1'b1;
        end

        // End of command: report and return to the reset state.
        if (r_in_last) begin
            if (ph == PH_QUOTE) begin
                n_qerr = 1'b1;
            end else if (ph == PH_WORD) begin
                n_wend = 1'b1;
            end
            ph            = PH_SEP;
            n_quote_dbl   = 1'b0;
            n_esc_pending = 1'b0;
        end
        n_phase = ph;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_phase       <= PH_SEP;
            r_quote_dbl   <= 1'b0;
            r_esc_pending <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (w_adv) begin
                r_phase       <= n_phase;
                r_quote_dbl   <= n_quote_dbl;
                r_esc_pending <= n_esc_pending;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
        if (w_adv) begin
            r_out_byte                  <= n_valid ? r_in_byte : '0;
            r_out_user[USR_BYTE_VALID]  <= n_valid;
            r_out_user[USR_WORD_END]    <= n_wend;
            r_out_user[USR_QUOTE_ERROR] <= n_qerr;
            r_out_last                  <= r_in_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tuser  = r_out_user;
    assign o_m_tlast  = r_out_last;

    // A quote error replaces the final word end and only comes with the last byte.
    a_qerr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[USR_QUOTE_ERROR]
            |-> o_m_tlast && !o_m_tuser[USR_WORD_END])
        else $error("quote error without command end or with word end");

    // The word byte is zero whenever it is not part of a word.
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[USR_BYTE_VALID] |-> o_m_tdata == '0)
        else $error("word byte not cleared");

    // The last byte of a command leaves the scanner in its reset state.
    a_cmd_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_in_last
            |=> r_phase == PH_SEP && !r_quote_dbl && !r_esc_pending)
        else $error("scanner state not cleared after command end");

    // An escape is never left pending across the end of a command.
    a_esc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && n_esc_pending |-> !r_in_last)
        else $error("escape pending on last byte");

endmodule

// File: verif/tb_shell_quote_word_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shell_quote_word_splitter
// Self-checking bench for the shell-style word splitter.
// ----------------------------------------------------------------------------
// A short table of hand-picked bytes covers blanks, quotes, escapes and the end
// of a command, with some results written out by hand. Random commands follow,
// most of them built from words, quoted runs and escape pairs, the rest noise.
// Every accepted request is run through a local splitter model, and each result
// is compared field by field with the oldest prediction. Both stream sides
// pause at random.
module tb_shell_quote_word_splitter;

    import sqws_pkg::*;

    localparam logic [BYTE_W-1:0] CH_NL = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_VT = 8'h0B;
    localparam logic [BYTE_W-1:0] CH_FF = 8'h0C;
    localparam int RANDOM_BYTES = 2000;
    localparam int MAX_PAUSE    = 12;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              byte_valid;
        logic              word_end;
        logic              quote_error;
        logic              done;
    } t_split_result;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              fin;
        logic              typed;   // want holds a hand-written result
        t_split_result     want;
    } t_byte_row;

    // Hand-picked bytes; typed rows carry the result the splitter must give.
    localparam t_byte_row BYTE_ROWS [25] = '{
        '{8'h61,     1'b0, 1'b1, '{8'h61, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{CH_SPACE,  1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{8'h00,     1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{8'hFF,     1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{CH_TAB,    1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{CH_DQUOTE, 1'b0, 1'b0, '0},
        '{8'h78,     1'b0, 1'b0, '0},
        '{CH_BSLASH, 1'b0, 1'b0, '0},
        '{CH_DQUOTE, 1'b0, 1'b0, '0},
        '{CH_SQUOTE, 1'b0, 1'b0, '0},
        '{CH_DQUOTE, 1'b0, 1'b0, '0},
        '{CH_SQUOTE, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
        '{CH_BSLASH, 1'b0, 1'b0, '0},
        '{CH_SPACE,  1'b0, 1'b0, '0},
        '{CH_NL,     1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b1}},
        '{CH_BSLASH, 1'b1, 1'b1, '{CH_BSLASH, 1'b1, 1'b1, 1'b0, 1'b1}},
        '{CH_DQUOTE, 1'b0, 1'b0, '0},
        '{CH_DQUOTE, 1'b0, 1'b0, '0},
        '{CH_CR,     1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{CH_VT,     1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{CH_BSLASH, 1'b0, 1'b0, '0},
        '{8'h71,     1'b1, 1'b1, '{8'h71, 1'b1, 1'b1, 1'b0, 1'b1}},
        '{CH_FF,     1'b0, 1'b0, '0},
        '{8'h08,     1'b0, 1'b0, '0},
        '{8'h0E,     1'b1, 1'b1, '{8'h0E, 1'b1, 1'b1, 1'b0, 1'b1}}
    };

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [BYTE_W-1:0] m_tdata;
    logic [USR_W-1:0]  m_tuser;
    logic              m_tlast;

    // Local copy of the scanner state.
    logic [PHASE_W-1:0] scan_ph   = PH_SEP;
    logic               quote_dbl = 1'b0;
    logic               esc_held  = 1'b0;

    t_split_result split_q[$];
    int            mismatches = 0;
    bit            s_burst    = 1'b0;

    shell_quote_word_splitter dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #(5_000_000);
        $display("Test completed with failures");
        $finish;
    end

    // Advances the local scanner by one byte and returns the result it gives.
    function automatic t_split_result split_byte(input logic [BYTE_W-1:0] c,
                                                 input logic fin);
        t_split_result      r;
        logic [PHASE_W-1:0] ph;
        r  = '0;
        // The unused phase code behaves as the separator phase.
        ph = (scan_ph == PH_WORD || scan_ph == PH_QUOTE) ? scan_ph : PH_SEP;
        if (esc_held) begin
            esc_held     = 1'b0;
            r.byte_valid = 1'b1;
            if (ph == PH_SEP) ph = PH_WORD;
        end else if (c == CH_BSLASH && !fin) begin
            esc_held = 1'b1;
            if (ph == PH_SEP) ph = PH_WORD;
        end else if (ph == PH_QUOTE) begin
            if (c == (quote_dbl ? CH_DQUOTE : CH_SQUOTE)) ph = PH_WORD;
            else r.byte_valid = 1'b1;
        end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            if (ph == PH_WORD) begin
                r.word_end = 1'b1;
                ph         = PH_SEP;
            end
        end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
            ph        = PH_QUOTE;
            quote_dbl = (c == CH_DQUOTE);
        end else begin
            ph           = PH_WORD;
            r.byte_valid = 1'b1;
        end
        if (fin) begin
            if (ph == PH_QUOTE) r.quote_error = 1'b1;
            else if (ph == PH_WORD) r.word_end = 1'b1;
            ph        = PH_SEP;
            quote_dbl = 1'b0;
            esc_held  = 1'b0;
        end
        scan_ph = ph;
        r.data  = r.byte_valid ? c : '0;
        r.done  = fin;
        return r;
    endfunction

    // Mostly quotes, backslashes and blanks; otherwise any byte at all.
    function automatic logic [BYTE_W-1:0] any_byte();
        case ($urandom_range(0, 7))
            0:       return CH_SQUOTE;
            1:       return CH_DQUOTE;
            2:       return CH_BSLASH;
            3:       return ($urandom_range(0, 1) != 0) ? CH_SPACE
                                                        : BYTE_W'($urandom_range(9, 13));
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] text_byte();
        if ($urandom_range(0, 5) == 0) return BYTE_W'($urandom_range(128, 255));
        return BYTE_W'($urandom_range(8'h61, 8'h7A));
    endfunction

    function automatic logic [BYTE_W-1:0] blank_byte();
        if ($urandom_range(0, 2) == 0) return BYTE_W'($urandom_range(9, 13));
        return CH_SPACE;
    endfunction

    // Sends one request; the prediction is queued once it has been accepted.
    task automatic send_byte(input logic [BYTE_W-1:0] c, input logic fin,
                             input logic typed, input t_split_result want);
        int            gap;
        t_split_result got;
        gap = s_burst ? 0 : $urandom_range(0, MAX_PAUSE);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        got = split_byte(c, fin);
        split_q.push_back(typed ? want : got);
    endtask

    task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    initial begin : stimulus
        logic [BYTE_W-1:0] cmd[$];
        logic [BYTE_W-1:0] qc;
        logic [BYTE_W-1:0] b;
        int                sent;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (BYTE_ROWS[i])
            send_byte(BYTE_ROWS[i].ch, BYTE_ROWS[i].fin, BYTE_ROWS[i].typed,
                      BYTE_ROWS[i].want);

        sent = 0;
        while (sent < RANDOM_BYTES) begin
            cmd.delete();
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 10)) cmd.push_back(any_byte());
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 3) == 0) cmd.push_back(blank_byte());
                    case ($urandom_range(0, 3))
                        0: begin
                            qc = ($urandom_range(0, 1) != 0) ? CH_DQUOTE : CH_SQUOTE;
                            cmd.push_back(qc);
                            repeat ($urandom_range(0, 4)) begin
                                b = ($urandom_range(0, 1) != 0) ? any_byte() : text_byte();
                                // The closing quote and a backslash must be escaped
                                // to stay inside the quoted run.
                                if (b == qc || b == CH_BSLASH || $urandom_range(0, 5) == 0)
                                    cmd.push_back(CH_BSLASH);
                                cmd.push_back(b);
                            end
                            // Now and then the quote is left open.
                            if ($urandom_range(0, 9) != 0) cmd.push_back(qc);
                        end
                        1: begin
                            cmd.push_back(CH_BSLASH);
                            cmd.push_back(any_byte());
                        end
                        default: repeat ($urandom_range(1, 5)) cmd.push_back(text_byte());
                    endcase
                    cmd.push_back(blank_byte());
                end
                if ($urandom_range(0, 5) == 0) cmd.push_back(CH_BSLASH);
                else if ($urandom_range(0, 1) == 0) void'(cmd.pop_back());
            end
            s_burst = ($urandom_range(0, 4) == 0);
            foreach (cmd[k])
                send_byte(cmd[k], k == cmd.size() - 1, 1'b0, '0);
            sent += cmd.size();
        end
        s_tvalid <= 1'b0;

        while (split_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Result side back-pressure, with bursts of no stalling.
    initial begin : drain
        int stall;
        int taken;
        bit m_burst;
        m_tready <= 1'b0;
        taken   = 0;
        m_burst = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (taken % 20 == 0) m_burst = ($urandom_range(0, 3) == 0);
            stall = m_burst ? 0 : $urandom_range(0, MAX_PAUSE);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            taken++;
        end
    end

    always @(posedge clk) begin : result_check
        t_split_result want;
        if (rst_n && m_tvalid && m_tready) begin
            if (split_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual data %h user %b last %b",
                         $time, m_tdata, m_tuser, m_tlast);
                mismatches++;
            end else begin
                want = split_q.pop_front();
                check_field("word_byte", want.data, m_tdata);
                check_field("byte_valid", BYTE_W'(want.byte_valid),
                            BYTE_W'(m_tuser[USR_BYTE_VALID]));
                check_field("word_end", BYTE_W'(want.word_end),
                            BYTE_W'(m_tuser[USR_WORD_END]));
                check_field("quote_error", BYTE_W'(want.quote_error),
                            BYTE_W'(m_tuser[USR_QUOTE_ERROR]));
                check_field("command_done", BYTE_W'(want.done), BYTE_W'(m_tlast));
            end
        end
    end

endmodule

// File: shell_quote_word_splitter.f
rtl/core/sqws_pkg.sv
rtl/core/shell_quote_word_splitter.sv
verif/tb_shell_quote_word_splitter.sv
